>>> src/bus_servo_command_framer_defines.svh
`ifndef BUS_SERVO_COMMAND_FRAMER_DEFINES_SVH
`define BUS_SERVO_COMMAND_FRAMER_DEFINES_SVH

// same-cycle implication, held off during reset
`define BSCF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define BSCF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bscf_pkg.sv
`default_nettype none

package bscf_pkg;

    typedef enum logic [2:0] {
        CMD_MOVE  = 3'd0,
        CMD_MOTOR = 3'd1,
        CMD_SERVO = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        AXIS_TILT = 2'd0,
        AXIS_PAN  = 2'd1,
        AXIS_ROLL = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        REG_TILT = 2'd0,
        REG_PAN  = 2'd1,
        REG_ROLL = 2'd2
    } t_reg;

    localparam int OFF_W     = 11;
    localparam int NUM_W     = 20;
    localparam int DEN_W     = 16;
    localparam int DIV_STEP  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;
    localparam int FRAME_LEN = 10;
    localparam int BODY_LEN  = 7;

    localparam logic [7:0]  HDR       = 8'h55;
    localparam logic [7:0]  LEN_LONG  = 8'h07;
    localparam logic [7:0]  LEN_SHORT = 8'h03;
    localparam logic [7:0]  OP_MOVE   = 8'h01;
    localparam logic [7:0]  OP_MODE   = 8'h1D;
    localparam logic [7:0]  OP_STOP   = 8'h0C;
    localparam logic [7:0]  OP_READ   = 8'h1C;
    localparam logic [15:0] ROLL_MAX  = 16'd1000;
    // ceil(2^17 / 3): exact divide by three for 16-bit operands
    localparam logic [15:0] DIV3_MUL  = 16'hAAAB;
    localparam logic [3:0]  END_LONG  = 4'd9;
    localparam logic [3:0]  END_SHORT = 4'd5;

    typedef struct packed {
        logic signed [OFF_W-1:0] tilt;
        logic signed [OFF_W-1:0] pan;
        logic signed [OFF_W-1:0] roll;
    } t_offsets;

    typedef struct packed {
        t_cmd        cmd;
        t_axis       axis;
        logic [15:0] pos;
        logic [15:0] speed;
        logic        t_en;
        logic        t_neg;
    } t_item;

endpackage

`default_nettype wire

>>> src/bscf_front.sv
`default_nettype none

module bscf_front
    import bscf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [2:0]        i_cmd,
    input  wire logic [1:0]        i_axis,
    input  wire logic [15:0]       i_target_angle,
    input  wire logic [15:0]       i_current_angle,
    input  wire logic              i_current_valid,
    input  wire logic [15:0]       i_speed,
    input  wire t_offsets          i_offsets,
    output logic                   o_vld,
    output logic [NUM_W-1:0]       o_num,
    output logic [DEN_W-1:0]       o_den,
    output t_item                  o_item
);

    logic                   legal;
    logic signed [OFF_W-1:0] off;
    logic [16:0]            off17;
    logic [16:0]            x;
    logic [16:0]            xabs;
    logic [16:0]            dd;
    logic [16:0]            dabs;
    logic [NUM_W-1:0]       dnum;

    // stage A
    logic                   r_a_vld;
    logic                   r_a_xneg;
    logic [12:0]            r_a_y;
    logic [NUM_W-1:0]       r_a_num;
    logic [DEN_W-1:0]       r_a_den;
    t_cmd                   r_a_cmd;
    t_axis                  r_a_axis;
    logic [15:0]            r_a_speed;
    logic                   r_a_ten;
    logic                   r_a_tneg;

    // stage B
    logic                   r_b_vld;
    logic [NUM_W-1:0]       r_b_num;
    logic [DEN_W-1:0]       r_b_den;
    t_item                  r_b_item;

    logic [28:0]            prod;
    logic [15:0]            mag;
    logic [15:0]            pos;
    t_item                  n_item;

    always_comb begin
        legal = (i_cmd inside {[CMD_MOVE:CMD_READ]}) && (i_axis inside {[AXIS_TILT:AXIS_ROLL]});
        case (i_axis)
            AXIS_TILT: off = i_offsets.tilt;
            AXIS_PAN:  off = i_offsets.pan;
            default:   off = i_offsets.roll;
        endcase
        off17 = {{(17-OFF_W){off[OFF_W-1]}}, off};
        // 24 * offset in servo units, added to the angle in 0.01 degree
        x     = {i_target_angle[15], i_target_angle} + (off17 << 4) + (off17 << 3);
        xabs  = x[16] ? 17'(-x) : x;
        dd    = {i_target_angle[15], i_target_angle} - {i_current_angle[15], i_current_angle};
        dabs  = dd[16] ? 17'(-dd) : dd;
        dnum  = ({4'b0, dabs[15:0]} << 3) + ({4'b0, dabs[15:0]} << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld && legal;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xneg  <= x[16];
            r_a_y     <= xabs[15:3];
            r_a_num   <= dnum;
            r_a_den   <= i_speed[15] ? 16'(-i_speed) : i_speed;
            r_a_cmd   <= t_cmd'(i_cmd);
            r_a_axis  <= t_axis'(i_axis);
            r_a_speed <= i_speed;
            r_a_ten   <= (i_speed != 16'd0) && i_current_valid;
            r_a_tneg  <= i_speed[15];
        end
    end

    // |x| / 24 = (|x| / 8) / 3, sign put back afterwards (truncation toward zero)
    always_comb begin
        prod = {16'b0, r_a_y} * {13'b0, DIV3_MUL};
        mag  = {4'b0, prod[28:17]};
        pos  = r_a_xneg ? 16'(-mag) : mag;
        if (r_a_axis == AXIS_ROLL) begin
            if (pos[15]) begin
                pos = 16'd0;
            end else if (pos > ROLL_MAX) begin
                pos = ROLL_MAX;
            end
        end
        n_item.cmd   = r_a_cmd;
        n_item.axis  = r_a_axis;
        n_item.pos   = pos;
        n_item.speed = r_a_speed;
        n_item.t_en  = r_a_ten;
        n_item.t_neg = r_a_tneg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_num  <= r_a_num;
            r_b_den  <= r_a_den;
            r_b_item <= n_item;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_num  = r_b_num;
    assign o_den  = r_b_den;
    assign o_item = r_b_item;

endmodule

`default_nettype wire

>>> src/bscf_div.sv
`default_nettype none

module bscf_div
    import bscf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire t_item             i_item,
    output logic                   o_vld,
    output logic [NUM_W-1:0]       o_quo,
    output t_item                  o_item
);

    // restoring divider, DIV_STEP quotient bits per stage; the numerator
    // shifts out at the top while quotient bits shift in at the bottom
    logic             r_vld  [DIV_STAGES];
    logic [NUM_W-1:0] r_num  [DIV_STAGES];
    logic [DEN_W-1:0] r_rem  [DIV_STAGES];
    logic [DEN_W-1:0] r_den  [DIV_STAGES];
    t_item            r_item [DIV_STAGES];

    logic [NUM_W-1:0] p_num  [DIV_STAGES];
    logic [DEN_W-1:0] p_rem  [DIV_STAGES];
    logic [DEN_W-1:0] p_den  [DIV_STAGES];

    logic [NUM_W-1:0] n_num  [DIV_STAGES];
    logic [DEN_W-1:0] n_rem  [DIV_STAGES];

    // stage inputs: the divider input for the first, the stage before otherwise
    always_comb begin
        p_num[0] = i_num;
        p_rem[0] = '0;
        p_den[0] = i_den;
        for (int s = 1; s < DIV_STAGES; s++) begin
            p_num[s] = r_num[s-1];
            p_rem[s] = r_rem[s-1];
            p_den[s] = r_den[s-1];
        end
    end

    always_comb begin
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < DIV_STAGES; s++) begin
            num = p_num[s];
            rem = p_rem[s];
            den = p_den[s];
            for (int k = 0; k < DIV_STEP; k++) begin
                trial = {rem, num[NUM_W-1]};
                num   = {num[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    trial  = trial - {1'b0, den};
                    num[0] = 1'b1;
                end
                rem = trial[DEN_W-1:0];
            end
            n_num[s] = num;
            n_rem[s] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= i_item;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_num[s] <= n_num[s];
                r_rem[s] <= n_rem[s];
                r_den[s] <= p_den[s];
            end
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_item[s] <= r_item[s-1];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_num[DIV_STAGES-1];
    assign o_item = r_item[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/bscf_frame.sv
`default_nettype none

module bscf_frame
    import bscf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [NUM_W-1:0]  i_quo,
    input  wire t_item             i_item,
    input  wire logic              i_stall,
    output logic                   o_en,
    output logic                   o_valid,
    output logic [7:0]             o_frame_byte,
    output logic                   o_last
);

    // body stage: id, length, opcode, four parameter bytes
    logic        r_c_vld;
    logic        r_c_short;
    logic [7:0]  r_c_byte [BODY_LEN];

    logic [7:0]  r_frame_store [FRAME_LEN];
    logic        r_busy;
    logic [3:0]  r_pos;
    logic [3:0]  r_end;

    logic        r_o_vld;
    logic [7:0]  r_o_byte;
    logic        r_o_last;

    logic [15:0] tval;
    logic [7:0]  n_byte [BODY_LEN];
    logic        n_short;
    logic [7:0]  sum_long;
    logic [7:0]  sum_short;
    logic        out_adv;
    logic        frame_free;
    logic        load;
    logic        en;

    always_comb begin
        if (!i_item.t_en) begin
            tval = 16'd0;
        end else if (!i_item.t_neg) begin
            tval = (i_quo > NUM_W'(32767)) ? 16'h7FFF : i_quo[15:0];
        end else begin
            tval = (i_quo > NUM_W'(32768)) ? 16'h8000 : 16'(-i_quo[15:0]);
        end

        n_byte[0] = {6'b0, i_item.axis} + 8'd1;
        n_byte[1] = LEN_LONG;
        n_byte[2] = OP_MODE;
        n_byte[3] = 8'd0;
        n_byte[4] = 8'd0;
        n_byte[5] = 8'd0;
        n_byte[6] = 8'd0;
        n_short   = 1'b0;
        case (i_item.cmd)
            CMD_MOVE: begin
                n_byte[2] = OP_MOVE;
                n_byte[3] = i_item.pos[7:0];
                n_byte[4] = i_item.pos[15:8];
                n_byte[5] = tval[7:0];
                n_byte[6] = tval[15:8];
            end
            CMD_MOTOR: begin
                n_byte[3] = 8'd1;
                n_byte[5] = i_item.speed[7:0];
                n_byte[6] = i_item.speed[15:8];
            end
            CMD_SERVO: begin
                n_byte[2] = OP_MODE;
            end
            CMD_STOP: begin
                n_byte[1] = LEN_SHORT;
                n_byte[2] = OP_STOP;
                n_short   = 1'b1;
            end
            default: begin
                n_byte[1] = LEN_SHORT;
                n_byte[2] = OP_READ;
                n_short   = 1'b1;
            end
        endcase
    end

    always_comb begin
        sum_short = r_c_byte[0] + r_c_byte[1] + r_c_byte[2];
        sum_long  = sum_short + r_c_byte[3] + r_c_byte[4] + r_c_byte[5] + r_c_byte[6];
        out_adv    = !r_o_vld || !i_stall;
        // the store can take a new frame as its last byte goes out
        frame_free = !r_busy || (out_adv && (r_pos == r_end));
        load       = r_c_vld && frame_free;
        en         = !r_c_vld || frame_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_short <= n_short;
            for (int i = 0; i < BODY_LEN; i++) begin
                r_c_byte[i] <= n_byte[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frame_store[0] <= HDR;
            r_frame_store[1] <= HDR;
            r_frame_store[2] <= r_c_byte[0];
            r_frame_store[3] <= r_c_byte[1];
            r_frame_store[4] <= r_c_byte[2];
            r_frame_store[5] <= r_c_short ? ~sum_short : r_c_byte[3];
            r_frame_store[6] <= r_c_byte[4];
            r_frame_store[7] <= r_c_byte[5];
            r_frame_store[8] <= r_c_byte[6];
            r_frame_store[9] <= ~sum_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= 4'd0;
            r_end   <= END_LONG;
            r_o_vld <= 1'b0;
        end else begin
            if (out_adv) begin
                r_o_vld <= r_busy;
                if (r_busy) begin
                    if (r_pos == r_end) begin
                        r_busy <= 1'b0;
                        r_pos  <= 4'd0;
                    end else begin
                        r_pos <= r_pos + 4'd1;
                    end
                end
            end
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= 4'd0;
                r_end  <= r_c_short ? END_SHORT : END_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_o_byte <= r_frame_store[r_pos];
            r_o_last <= (r_pos == r_end);
        end
    end

    assign o_en         = en;
    assign o_valid      = r_o_vld;
    assign o_frame_byte = r_o_byte;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

>>> src/bus_servo_command_framer.sv
// Gimbal servo command framer.
// Input channel (i_valid / o_stall): one command per item; an item is taken
// at a clock edge with i_valid high and o_stall low. Items with an unused
// command or axis code are taken and produce no bytes.
// Output channel (o_valid / i_stall): the frame, one byte per item, o_last
// high on the checksum byte. Long frames are 10 bytes, stop and read frames 6.
// The first byte of a frame passes front stages A and B, the divider stages,
// the body stage, the frame store and the output byte register; the rest
// follow one a cycle while i_stall is low. Throughput: a command may be taken
// every cycle into the 8-stage pipeline (two front stages, five divider
// stages for the move time, one body stage); a single byte output reads the
// frame store, which holds one frame at a time and takes the next as its last
// byte goes out. Receiver stall: the output byte holds, the pipeline fills and
// o_stall rises once the body stage is full; nothing is dropped or repeated.
// Reset (synchronous, i_rst_n low): pipeline and output empty, offsets zero.
// Offsets are written over the APB port at 0x0 tilt, 0x4 pan, 0x8 roll; the
// user must write them only while the block is idle, which it does not enforce.
`default_nettype none
`include "bus_servo_command_framer_defines.svh"

module bus_servo_command_framer
    import bscf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [1:0]  i_axis,
    input  wire logic [15:0] i_target_angle,
    input  wire logic [15:0] i_current_angle,
    input  wire logic        i_current_valid,
    input  wire logic [15:0] i_speed,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_frame_byte,
    output logic             o_last,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_offsets          r_offsets;
    logic              en;

    logic              f_vld;
    logic [NUM_W-1:0]  f_num;
    logic [DEN_W-1:0]  f_den;
    t_item             f_item;

    logic              d_vld;
    logic [NUM_W-1:0]  d_quo;
    t_item             d_item;

    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TILT: r_offsets.tilt <= pwdata[OFF_W-1:0];
                REG_PAN:  r_offsets.pan  <= pwdata[OFF_W-1:0];
                REG_ROLL: r_offsets.roll <= pwdata[OFF_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TILT: prdata = {{(32-OFF_W){r_offsets.tilt[OFF_W-1]}}, r_offsets.tilt};
            REG_PAN:  prdata = {{(32-OFF_W){r_offsets.pan[OFF_W-1]}}, r_offsets.pan};
            REG_ROLL: prdata = {{(32-OFF_W){r_offsets.roll[OFF_W-1]}}, r_offsets.roll};
            default:  prdata = 32'd0;
        endcase
    end

    assign o_stall = !en;

    bscf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (i_valid),
        .i_cmd           (i_cmd),
        .i_axis          (i_axis),
        .i_target_angle  (i_target_angle),
        .i_current_angle (i_current_angle),
        .i_current_valid (i_current_valid),
        .i_speed         (i_speed),
        .i_offsets       (r_offsets),
        .o_vld           (f_vld),
        .o_num           (f_num),
        .o_den           (f_den),
        .o_item          (f_item)
    );

    bscf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_item  (f_item),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_item  (d_item)
    );

    bscf_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (d_vld),
        .i_quo        (d_quo),
        .i_item       (d_item),
        .i_stall      (i_stall),
        .o_en         (en),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

    // a frame's bytes leave without gaps
    `BSCF_ASSERT_NXT(a_frame_gapless, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid, "gap inside frame")
    // the byte after a checksum opens a new frame
    `BSCF_ASSERT_NXT(a_frame_header, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_valid || (o_frame_byte == HDR), "frame does not start with header")
    // the first two bytes of every frame are headers, so a header never carries last
    `BSCF_ASSERT_IMP(a_last_not_hdr_start, i_clk, i_rst_n, o_valid && o_last && $past(o_valid && !i_stall && o_last), 1'b0, "one-byte frame")

endmodule

`default_nettype wire
